/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros
// concurrent assertion shorthands for the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies consequence in the same cycle
`define ASSERT_IMPLY(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/lif_pkg.sv */
// ----------------------------------------------------------------------------
// lif_pkg
// shared constants and controller/datapath interface types
// ----------------------------------------------------------------------------
package lif_pkg;

  localparam int NEURONS = 256;
  localparam int DT_BITS = 20;
  localparam int NIDX_W  = (NEURONS > 1) ? $clog2(NEURONS) : 1;
  localparam int CNT_W   = (DT_BITS > 1) ? $clog2(DT_BITS) : 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DECAY     = 3'd0,
    CFG_INV_CAP   = 3'd1,
    CFG_THRESHOLD = 3'd2,
    CFG_RESET_POT = 3'd3,
    CFG_REFRACT   = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic load;
    logic check;
    logic step;
    logic mul;
    logic add;
    logic write;
  } lif_cmd_t;

  typedef struct packed {
    logic in_range;
    logic more;
    logic late;
    logic spike;
    logic out_free;
  } lif_status_t;

endpackage

/* hw/rtl/lif_neuron_event_update.sv */
// ----------------------------------------------------------------------------
// lif_neuron_event_update
// event driven leaky integrate and fire neuron array with spike output
// ----------------------------------------------------------------------------
// input channel: in_valid/in_ready carry one synaptic event (neuron,
//   event_time, weight, more_same_time); one transaction per event
// output channel: out_valid/out_ready carry one spike (spike_neuron,
//   spike_time) per group that reaches threshold
// config channel: cfg_valid/cfg_ready with cfg_index and cfg_data, always
//   ready; write only while no event is in flight
// an event is taken only when the block is idle; after an open-group, an
//   out of range or a late event the block goes from check back to idle
// a closing event runs the decay power unit one exponent bit per cycle,
//   then multiply, add and write back; its spike is registered into
//   out_valid at write back, and the next event is taken back in idle
// the spike sits in an output register, so the next event is accepted
//   while it waits; a second spike stalls in write back until it drains
// reset restores the register defaults, clears the open group and marks
//   every neuron as zero voltage and zero last update time
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lif_neuron_event_update
  import lif_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            neuron,
  input  logic [31:0]           event_time,
  input  logic signed [15:0]    weight,
  input  logic                  more_same_time,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            spike_neuron,
  output logic [31:0]           spike_time,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  lif_cmd_t    cmd;
  lif_status_t st;

  assign cfg_ready = 1'b1;

  lif_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  lif_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .neuron         (neuron),
    .event_time     (event_time),
    .weight         (weight),
    .more_same_time (more_same_time),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .spike_neuron   (spike_neuron),
    .spike_time     (spike_time),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  `ASSERT_NEXT(a_one_event, clk, rst, in_valid && in_ready, !in_ready, "event taken while busy")
  `ASSERT_IMPLY(a_cmd_onehot, clk, rst, 1'b1, $onehot0(cmd), "more than one datapath command")
  `ASSERT_IMPLY(a_spike_src, clk, rst, $rose(out_valid), $past(cmd.write), "spike without write back")
  `ASSERT_IMPLY(a_write_free, clk, rst, cmd.write && st.spike, st.out_free, "spike overwrites output")

endmodule

/* hw/rtl/lif_ctrl.sv */
// ----------------------------------------------------------------------------
// lif_ctrl
// sequencer for one event: check, decay power loop, update, write back
// ----------------------------------------------------------------------------
module lif_ctrl
  import lif_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  lif_status_t st,
  output lif_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_POW,
    S_MUL,
    S_ADD,
    S_WRITE
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;
  logic             wr_go;

  assign in_ready = (state == S_IDLE);
  assign wr_go    = !st.spike || st.out_free;

  always_comb begin
    cmd       = '0;
    cmd.load  = (state == S_IDLE) && in_valid;
    cmd.check = (state == S_CHECK);
    cmd.step  = (state == S_POW);
    cmd.mul   = (state == S_MUL);
    cmd.add   = (state == S_ADD);
    cmd.write = (state == S_WRITE) && wr_go;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_CHECK;
        end
        S_CHECK: begin
          cnt <= '0;
          if (!st.in_range || st.more || st.late) state <= S_IDLE;
          else state <= S_POW;
        end
        S_POW: begin
          if (cnt == CNT_W'(DT_BITS - 1)) state <= S_MUL;
          else cnt <= cnt + 1'b1;
        end
        S_MUL: state <= S_ADD;
        S_ADD: state <= S_WRITE;
        S_WRITE: begin
          if (wr_go) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/lif_dp.sv */
// ----------------------------------------------------------------------------
// lif_dp
// neuron state memories, group sum, decay power unit, update and spike output
// ----------------------------------------------------------------------------
module lif_dp
  import lif_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  lif_cmd_t              cmd,
  output lif_status_t           st,
  input  logic [7:0]            neuron,
  input  logic [31:0]           event_time,
  input  logic signed [15:0]    weight,
  input  logic                  more_same_time,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            spike_neuron,
  output logic [31:0]           spike_time,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration
  logic [15:0]        decay;
  logic [15:0]        inv_cap;
  logic signed [15:0] thresh;
  logic signed [15:0] reset_pot;
  logic [19:0]        refract;

  // neuron state
  logic signed [15:0] mem_v [NEURONS];
  logic [31:0]        mem_t [NEURONS];
  logic [NEURONS-1:0] vld;

  // latched event and read data
  logic [7:0]         in_n;
  logic [31:0]        in_t;
  logic signed [15:0] in_w;
  logic               in_more;
  logic signed [15:0] rd_v;
  logic [31:0]        rd_t;
  logic               rd_ok;
  logic [NIDX_W-1:0]  addr;
  logic [NIDX_W-1:0]  rd_addr;

  // group sum
  logic signed [19:0] pend_w;
  logic               pend_act;
  logic signed [19:0] pend_use;
  logic signed [20:0] sum_wide;
  logic signed [19:0] sum_sat;
  logic signed [19:0] sum_r;

  // decay power
  logic [31:0]        last_t;
  logic [31:0]        dt;
  logic               gap;
  logic [16:0]        res;
  logic [15:0]        base;
  logic [DT_BITS-1:0] dt_sh;
  logic [33:0]        res_rnd;
  logic [32:0]        base_rnd;

  // update
  logic signed [15:0] v_cur;
  logic signed [33:0] pv;
  logic signed [36:0] pj;
  logic signed [17:0] v_dec;
  logic signed [28:0] jump;
  logic signed [29:0] v_sum;
  logic signed [15:0] v_sat;
  logic signed [15:0] v_new;
  logic               spike;
  logic [32:0]        end_wide;
  logic [31:0]        end_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      decay     <= 16'd65470;
      inv_cap   <= 16'd256;
      thresh    <= 16'sd2560;
      reset_pot <= 16'sd0;
      refract   <= 20'd2048;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DECAY:     decay     <= cfg_data[15:0];
        CFG_INV_CAP:   inv_cap   <= cfg_data[15:0];
        CFG_THRESHOLD: thresh    <= $signed(cfg_data[15:0]);
        CFG_RESET_POT: reset_pot <= $signed(cfg_data[15:0]);
        CFG_REFRACT:   refract   <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  assign addr    = NIDX_W'(neuron);
  assign rd_addr = NIDX_W'(in_n);

  // state memories, read at accept, written at the end of an update
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd_v <= mem_v[addr];
      rd_t <= mem_t[addr];
    end
    if (cmd.write) begin
      mem_v[rd_addr] <= spike ? reset_pot : v_new;
      mem_t[rd_addr] <= spike ? end_t : in_t;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      rd_ok <= 1'b0;
    end else begin
      if (cmd.load) rd_ok <= vld[addr];
      if (cmd.write) vld[rd_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_n    <= neuron;
      in_t    <= event_time;
      in_w    <= weight;
      in_more <= more_same_time;
    end
  end

  // group sum with 20 bit saturation
  always_comb begin
    pend_use = pend_act ? pend_w : 20'sd0;
    sum_wide = 21'(pend_use) + 21'(in_w);
    if (sum_wide[20] != sum_wide[19]) sum_sat = sum_wide[20] ? 20'sh80000 : 20'sh7FFFF;
    else sum_sat = sum_wide[19:0];
  end

  assign last_t = rd_ok ? rd_t : 32'd0;
  assign dt     = in_t - last_t;
  assign gap    = ((33'({1'b0, dt}) >> DT_BITS) != 33'd0);

  assign st.in_range = (32'(in_n) < NEURONS);
  assign st.more     = in_more;
  assign st.late     = (in_t < last_t);
  assign st.spike    = spike;
  assign st.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_w   <= '0;
      pend_act <= 1'b0;
    end else if (cmd.check && st.in_range) begin
      pend_w   <= in_more ? sum_sat : 20'sd0;
      pend_act <= in_more;
    end
  end

  // decay factor by squaring, one exponent bit per cycle
  assign res_rnd  = 34'(res) * 34'(base) + 34'd32768;
  assign base_rnd = 33'(base) * 33'(base) + 33'd32768;

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      sum_r <= sum_sat;
      res   <= gap ? 17'd0 : 17'd65536;
      base  <= decay;
      dt_sh <= dt[DT_BITS-1:0];
    end else if (cmd.step) begin
      if (dt_sh[0]) res <= res_rnd[32:16];
      base  <= base_rnd[31:16];
      dt_sh <= dt_sh >> 1;
    end
  end

  // decayed voltage and input jump, rounded half up
  assign v_cur = rd_ok ? rd_v : 16'sd0;
  assign pv    = 34'(v_cur) * 34'($signed({1'b0, res}));
  assign pj    = 37'(sum_r) * 37'($signed({1'b0, inv_cap}));

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      v_dec <= 18'((pv + 34'sd32768) >>> 16);
      jump  <= 29'((pj + 37'sd128) >>> 8);
    end
  end

  always_comb begin
    v_sum = 30'(v_dec) + 30'(jump);
    if (v_sum > 30'sd32767) v_sat = 16'sh7FFF;
    else if (v_sum < -30'sd32768) v_sat = 16'sh8000;
    else v_sat = v_sum[15:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.add) begin
      v_new <= v_sat;
      spike <= (v_sat >= thresh);
    end
  end

  assign end_wide = {1'b0, in_t} + 33'(refract);
  assign end_t    = end_wide[32] ? 32'hFFFF_FFFF : end_wide[31:0];

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.write && spike) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write && spike) begin
      spike_neuron <= in_n;
      spike_time   <= in_t;
    end
  end

endmodule
